FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/slm_pkg.sv
`default_nettype none
package slm_pkg;

  localparam int DEPTH     = 16;
  localparam int RUN_LIMIT = 16;
  localparam int MAX_RUN   = (DEPTH < RUN_LIMIT) ? DEPTH : RUN_LIMIT;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W    = $clog2(DEPTH + 1);
  localparam int IDX_W     = $clog2(MAX_RUN + 1);
  localparam int CNT_W     = 5;
  localparam int VAL_W     = 32;

  localparam logic [1:0] CMD_PUSH_A = 2'd0;
  localparam logic [1:0] CMD_PUSH_B = 2'd1;
  localparam logic [1:0] CMD_MERGE  = 2'd2;

  localparam logic [CNT_W-1:0] ELEM_CNT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [VAL_W-1:0] value;
  } slm_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] merged_value;
    logic                    last;
  } slm_out_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic merge_start;
    logic pick;
  } slm_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic last_pick;
  } slm_sts_t;

endpackage
`default_nettype wire

FILE: rtl/slm_ram.sv
`default_nettype none
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/slm_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module slm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       command,
  input  wire slm_pkg::slm_sts_t sts,
  output logic                  busy,
  output slm_pkg::slm_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  logic [1:0] st_r;
  logic [1:0] st_nxt;
  logic       accept;

  assign busy   = (st_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd.push_a      = accept && (command == slm_pkg::CMD_PUSH_A);
    cmd.push_b      = accept && (command == slm_pkg::CMD_PUSH_B);
    cmd.merge_start = accept && (command == slm_pkg::CMD_MERGE);
    cmd.pick        = (st_r == ST_CMP);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd.merge_start && !sts.len_zero) begin
          st_nxt = ST_RD;
        end
      end
      ST_RD: begin
        st_nxt = ST_CMP;
      end
      ST_CMP: begin
        st_nxt = sts.last_pick ? ST_IDLE : ST_RD;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  `ASSERT_NEXT(a_busy_after_merge, cmd.merge_start && !sts.len_zero, busy, "merge did not start")
  `ASSERT_NEXT(a_idle_after_last, cmd.pick && sts.last_pick, !busy, "busy after last item")

endmodule
`default_nettype wire

FILE: rtl/slm_dp.sv
`default_nettype none
`include "assert_macros.svh"
module slm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire slm_pkg::slm_cmd_t            cmd,
  input  wire logic signed [slm_pkg::VAL_W-1:0] push_value,
  input  wire logic                         cfg_we,
  input  wire logic [slm_pkg::CNT_W-1:0]    cfg_wdata,
  output slm_pkg::slm_sts_t                 sts,
  output logic                              out_valid,
  output slm_pkg::slm_out_t                 out_item
);

  logic [slm_pkg::CNT_W-1:0]  elem_cnt_r;
  logic [slm_pkg::FILL_W-1:0] fill_a_r;
  logic [slm_pkg::FILL_W-1:0] fill_b_r;
  logic [slm_pkg::IDX_W-1:0]  ia_r;
  logic [slm_pkg::IDX_W-1:0]  ib_r;
  logic [slm_pkg::IDX_W-1:0]  n_r;
  logic [slm_pkg::IDX_W:0]    rem_r;
  logic                       out_valid_r;
  slm_pkg::slm_out_t          out_r;

  logic [slm_pkg::CNT_W-1:0]  n_cfg;
  logic [slm_pkg::IDX_W-1:0]  n_run;
  logic                       full_a;
  logic                       full_b;
  logic [slm_pkg::VAL_W-1:0]  a_rd;
  logic [slm_pkg::VAL_W-1:0]  b_rd;
  logic                       sel_a;

  assign n_cfg  = (elem_cnt_r > slm_pkg::CNT_W'(slm_pkg::MAX_RUN))
                  ? slm_pkg::CNT_W'(slm_pkg::MAX_RUN) : elem_cnt_r;
  assign n_run  = slm_pkg::IDX_W'(n_cfg);
  assign full_a = (fill_a_r == slm_pkg::FILL_W'(slm_pkg::DEPTH));
  assign full_b = (fill_b_r == slm_pkg::FILL_W'(slm_pkg::DEPTH));

  slm_ram #(.WIDTH(slm_pkg::VAL_W), .DEPTH(slm_pkg::DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (cmd.push_a && !full_a),
    .waddr (slm_pkg::ADDR_W'(fill_a_r)),
    .wdata (push_value),
    .raddr (slm_pkg::ADDR_W'(ia_r)),
    .rdata (a_rd)
  );

  slm_ram #(.WIDTH(slm_pkg::VAL_W), .DEPTH(slm_pkg::DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (cmd.push_b && !full_b),
    .waddr (slm_pkg::ADDR_W'(fill_b_r)),
    .wdata (push_value),
    .raddr (slm_pkg::ADDR_W'(ib_r)),
    .rdata (b_rd)
  );

  // list A wins ties
  assign sel_a = (ia_r < n_r) && ((ib_r >= n_r) || ($signed(a_rd) <= $signed(b_rd)));

  always_comb begin
    sts.len_zero  = (n_cfg == '0);
    sts.last_pick = (rem_r == (slm_pkg::IDX_W+1)'(1));
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r  <= slm_pkg::ELEM_CNT_RESET;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        elem_cnt_r <= cfg_wdata;
      end
      if (cmd.merge_start) begin
        fill_a_r <= '0;
        fill_b_r <= '0;
      end else begin
        if (cmd.push_a && !full_a) begin
          fill_a_r <= fill_a_r + slm_pkg::FILL_W'(1);
        end
        if (cmd.push_b && !full_b) begin
          fill_b_r <= fill_b_r + slm_pkg::FILL_W'(1);
        end
      end
      out_valid_r <= cmd.pick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge_start) begin
      ia_r  <= '0;
      ib_r  <= '0;
      n_r   <= n_run;
      rem_r <= {n_run, 1'b0};
    end else if (cmd.pick) begin
      if (sel_a) begin
        ia_r <= ia_r + slm_pkg::IDX_W'(1);
      end else begin
        ib_r <= ib_r + slm_pkg::IDX_W'(1);
      end
      rem_r <= rem_r - (slm_pkg::IDX_W+1)'(1);
    end
    if (cmd.pick) begin
      out_r.merged_value <= sel_a ? a_rd : b_rd;
      out_r.last         <= sts.last_pick;
    end
  end

  `ASSERT_NOW(a_fill_a_bound, 1'b1, fill_a_r <= slm_pkg::FILL_W'(slm_pkg::DEPTH), "A overflow")
  `ASSERT_NOW(a_fill_b_bound, 1'b1, fill_b_r <= slm_pkg::FILL_W'(slm_pkg::DEPTH), "B overflow")
  `ASSERT_NOW(a_idx_bound, cmd.pick, (ia_r <= n_r) && (ib_r <= n_r) && (rem_r != '0), "index")

endmodule
`default_nettype wire

FILE: rtl/sorted_list_merger_top.sv
`default_nettype none
// Two-way merge of two ascending lists of signed 32-bit values.
// Input: an item (command, value) is taken when start is high and busy is low.
//   A push to list A or list B never raises busy; a push into
//   a full list is dropped. Pushes may follow each other every cycle.
// Merge: emits element_count entries of each list (capped at the list depth
//   and 16) in ascending order, list A first on ties, last flagged on the
//   final item. Both fill counts are cleared when the merge is taken.
//   Each result is a read of both list RAMs, then a compare and select, then
//   the registered result on the result ports; busy stays high until the
//   last result is selected, so no new item is taken during a merge.
//   element_count of zero returns no results and leaves busy low.
// Config: cfg_we writes element_count (reset 16); write only while idle.
// Results: out_valid marks out_item for one cycle; the receiver cannot stall.
// Reset (rst_n low, synchronous): fill counts cleared, controller idle,
//   no result pending; list contents are not cleared.
module sorted_list_merger_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire slm_pkg::slm_in_t          in_item,
  input  wire logic                      cfg_we,
  input  wire logic [slm_pkg::CNT_W-1:0] cfg_wdata,
  output logic                           out_valid,
  output slm_pkg::slm_out_t              out_item
);

  slm_pkg::slm_cmd_t cmd;
  slm_pkg::slm_sts_t sts;

  slm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_item.command),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  slm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .push_value (in_item.value),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

FILE: tb/sv/slm_merge_checker.sv
`default_nettype none
module slm_merge_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire slm_pkg::slm_in_t          in_item,
  input  wire logic                      cfg_we,
  input  wire logic [slm_pkg::CNT_W-1:0] cfg_wdata,
  input  wire logic                      out_valid,
  input  wire slm_pkg::slm_out_t         out_item,
  output int                             fail_count,
  output int                             pending
);

  logic signed [slm_pkg::VAL_W-1:0] list_a [slm_pkg::DEPTH];
  logic signed [slm_pkg::VAL_W-1:0] list_b [slm_pkg::DEPTH];
  int                               fill_a;
  int                               fill_b;
  logic [slm_pkg::CNT_W-1:0]        elem_count;
  slm_pkg::slm_out_t                merged_q [$];
  int                               result_idx;

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic merge_lists();
    int                run_len;
    int                ia;
    int                ib;
    int                k;
    slm_pkg::slm_out_t r;
    run_len = (elem_count > slm_pkg::MAX_RUN) ? slm_pkg::MAX_RUN : int'(elem_count);
    ia = 0;
    ib = 0;
    for (k = 0; k < 2 * run_len; k++) begin
      if (ia < run_len && (ib >= run_len || list_a[ia] <= list_b[ib])) begin
        r.merged_value = list_a[ia];
        ia++;
      end else begin
        r.merged_value = list_b[ib];
        ib++;
      end
      r.last = (k == 2 * run_len - 1);
      merged_q.push_back(r);
    end
    fill_a = 0;
    fill_b = 0;
  endtask

  always @(posedge clk) begin
    slm_pkg::slm_out_t exp_r;
    if (!rst_n) begin
      fill_a     = 0;
      fill_b     = 0;
      elem_count = slm_pkg::ELEM_CNT_RESET;
      result_idx = 0;
      fail_count = 0;
      merged_q.delete();
    end else begin
      if (cfg_we)
        elem_count = cfg_wdata;
      if (start && !busy) begin
        case (in_item.command)
          slm_pkg::CMD_PUSH_A: if (fill_a < slm_pkg::DEPTH) begin
            list_a[fill_a] = in_item.value;
            fill_a++;
          end
          slm_pkg::CMD_PUSH_B: if (fill_b < slm_pkg::DEPTH) begin
            list_b[fill_b] = in_item.value;
            fill_b++;
          end
          slm_pkg::CMD_MERGE: merge_lists();
          default: ;
        endcase
      end
      if (out_valid) begin
        if (merged_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d last %0b",
                                    out_item.merged_value, out_item.last));
        end else begin
          exp_r = merged_q.pop_front();
          if (out_item.merged_value !== exp_r.merged_value)
            report_mismatch($sformatf("result %0d: merged_value expected %0d got %0d",
                                      result_idx, exp_r.merged_value,
                                      out_item.merged_value));
          if (out_item.last !== exp_r.last)
            report_mismatch($sformatf("result %0d: last expected %0b got %0b",
                                      result_idx, exp_r.last, out_item.last));
        end
        result_idx++;
      end
    end
    pending = merged_q.size();
  end

endmodule
`default_nettype wire

FILE: tb/sv/sorted_list_merger_top_tb.sv
`default_nettype none
module sorted_list_merger_top_tb;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 2000;
  localparam int         ITEM_TARGET = 450;
  localparam int         DRAIN_WAIT  = 20;
  localparam int         CFG_WAIT    = 8;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      start     = 1'b0;
  logic                      busy;
  slm_pkg::slm_in_t          in_item   = '0;
  logic                      cfg_we    = 1'b0;
  logic [slm_pkg::CNT_W-1:0] cfg_wdata = '0;
  logic                      out_valid;
  slm_pkg::slm_out_t         out_item;
  int                        fail_count;
  int                        pending;

  int stall_cycles = 0;
  bit idle_on      = 1'b1;
  int fill_a       = 0;
  int fill_b       = 0;
  int hw_a         = 0;
  int hw_b         = 0;
  int run_len      = slm_pkg::MAX_RUN;
  int useful       = 0;

  sorted_list_merger_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  slm_merge_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("sorted_list_merger_top regression: fail");
      $finish;
    end
  end

  // true when a merge reads only entries written since reset
  function automatic bit merge_ok();
    return hw_a >= run_len && hw_b >= run_len;
  endfunction

  function automatic logic signed [slm_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4, 5:    return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_len(int hw);
    int lo;
    lo = (hw >= run_len) ? 0 : run_len;
    if ($urandom_range(0, 9) < 2)
      return $urandom_range(lo, run_len + 3);
    return run_len;
  endfunction

  function automatic int pick_count(int phase);
    case (phase % 8)
      0:       return 16;
      1:       return 1;
      2:       return 31;
      3:       return 0;
      4:       return 17;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic send_item(logic [1:0] cmd, logic signed [slm_pkg::VAL_W-1:0] v);
    slm_pkg::slm_in_t it;
    it.command = cmd;
    it.value   = v;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 99) < 12) begin
      start   <= 1'b0;
      in_item <= slm_pkg::slm_in_t'({$urandom} ^ {$urandom, 2'b00});
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    case (cmd)
      slm_pkg::CMD_PUSH_A: if (fill_a < slm_pkg::DEPTH) begin
        fill_a++;
        useful++;
        if (fill_a > hw_a) hw_a = fill_a;
      end
      slm_pkg::CMD_PUSH_B: if (fill_b < slm_pkg::DEPTH) begin
        fill_b++;
        useful++;
        if (fill_b > hw_b) hw_b = fill_b;
      end
      slm_pkg::CMD_MERGE: begin
        fill_a = 0;
        fill_b = 0;
        useful++;
      end
      default: ;
    endcase
  endtask

  // element_count write, only once every expected item is out
  task automatic set_count(int cnt);
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CFG_WAIT) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= slm_pkg::CNT_W'(cnt);
    @(negedge clk);
    cfg_we  <= 1'b0;
    run_len = (cnt > slm_pkg::MAX_RUN) ? slm_pkg::MAX_RUN : cnt;
  endtask

  task automatic run_sequence();
    int la;
    int lb;
    int i;
    int qa [$];
    int qb [$];
    la = pick_len(hw_a);
    lb = pick_len(hw_b);
    for (i = 0; i < la; i++) qa.push_back(pick_value());
    for (i = 0; i < lb; i++) qb.push_back(pick_value());
    if (la > 0 && lb > 0 && $urandom_range(0, 2) == 0)
      qb[$urandom_range(0, lb - 1)] = qa[$urandom_range(0, la - 1)];
    if ($urandom_range(0, 9) != 0) begin
      qa.sort();
      qb.sort();
    end
    while (qa.size() != 0 || qb.size() != 0) begin
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1))
        send_item(slm_pkg::CMD_PUSH_A, qa.pop_front());
      else
        send_item(slm_pkg::CMD_PUSH_B, qb.pop_front());
      if ($urandom_range(0, 29) == 0)
        send_item(CMD_UNUSED, $urandom);
    end
    send_item(slm_pkg::CMD_MERGE, $urandom);
  endtask

  task automatic run_noise();
    int         n;
    logic [1:0] cmd;
    n = $urandom_range(3, 10);
    repeat (n) begin
      cmd = 2'($urandom_range(0, 3));
      if (cmd == slm_pkg::CMD_MERGE && !merge_ok())
        cmd = slm_pkg::CMD_PUSH_A;
      send_item(cmd, pick_value());
    end
  endtask

  initial begin
    int phase;
    int phase_base;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // ties on the extremes, list A first
    set_count(4);
    send_item(slm_pkg::CMD_PUSH_A, 32'h8000_0000);
    send_item(slm_pkg::CMD_PUSH_B, 32'h8000_0000);
    send_item(slm_pkg::CMD_PUSH_A, -5);
    send_item(slm_pkg::CMD_PUSH_B, -5);
    send_item(slm_pkg::CMD_PUSH_A, 0);
    send_item(slm_pkg::CMD_PUSH_B, 1);
    send_item(slm_pkg::CMD_PUSH_A, 32'h7fff_ffff);
    send_item(slm_pkg::CMD_PUSH_B, 32'h7fff_ffff);
    send_item(CMD_UNUSED, $urandom);
    send_item(slm_pkg::CMD_MERGE, $urandom);
    // stale entries behind a fresh head
    send_item(slm_pkg::CMD_PUSH_B, 3);
    send_item(slm_pkg::CMD_MERGE, $urandom);
    // zero length: no items, fills still cleared
    set_count(0);
    send_item(slm_pkg::CMD_PUSH_A, 9);
    send_item(slm_pkg::CMD_MERGE, $urandom);

    useful = 0;
    phase  = 0;
    while (useful < ITEM_TARGET) begin
      set_count(pick_count(phase));
      idle_on    = !(phase == 2 || phase == 3);
      phase_base = useful;
      while (useful - phase_base < 40 && useful < ITEM_TARGET) begin
        if ($urandom_range(0, 4) == 0)
          run_noise();
        else
          run_sequence();
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("sorted_list_merger_top regression: pass");
    else
      $display("sorted_list_merger_top regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
